>>> src/asgr_pkg.sv
// Package: shared types, character codes and palette tables for the SGR colour parser.
package asgr_pkg;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 24;
    localparam int CODE_W  = 7;

    localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RESET = 24'hCCCCCC;

    localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_FINAL_M   = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9   = 8'h39;

    localparam logic [CODE_W-1:0] CODE_RESET     = 7'd0;
    localparam logic [CODE_W-1:0] CODE_BOLD      = 7'd1;
    localparam logic [CODE_W-1:0] CODE_FG_FIRST  = 7'd30;
    localparam logic [CODE_W-1:0] CODE_FG_LAST   = 7'd37;
    localparam logic [CODE_W-1:0] CODE_FG_DFLT   = 7'd39;
    localparam logic [CODE_W-1:0] CODE_BR_FIRST  = 7'd90;
    localparam logic [CODE_W-1:0] CODE_BR_LAST   = 7'd97;
    localparam logic [CODE_W-1:0] CODE_MAX       = 7'd127;

    typedef enum logic [1:0] {
        ST_TEXT = 2'd0,
        ST_ESC  = 2'd1,
        ST_CSI  = 2'd2
    } scan_state_t;

    function automatic logic [COLOR_W-1:0] pal_normal(input logic [2:0] idx);
        logic [COLOR_W-1:0] col;
        case (idx)
            3'd0:    col = 24'h282C34;
            3'd1:    col = 24'hE06C75;
            3'd2:    col = 24'h98C379;
            3'd3:    col = 24'hE5C07B;
            3'd4:    col = 24'h61AFEF;
            3'd5:    col = 24'hC678DD;
            3'd6:    col = 24'h56B6C2;
            default: col = 24'hABB2BF;
        endcase
        return col;
    endfunction

    function automatic logic [COLOR_W-1:0] pal_bright(input logic [2:0] idx);
        logic [COLOR_W-1:0] col;
        case (idx)
            3'd0:    col = 24'h5C6370;
            3'd1:    col = 24'hEF596F;
            3'd2:    col = 24'hA6E22E;
            3'd3:    col = 24'hE6DB74;
            3'd4:    col = 24'h66D9EF;
            3'd5:    col = 24'hAE81FF;
            3'd6:    col = 24'hA1EFE4;
            default: col = 24'hF8F8F2;
        endcase
        return col;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'hAA, 8'hB5, 8'hBA})
              || ((c >= 8'hC0) && (c != 8'hD7) && (c != 8'hF7));
        return hit;
    endfunction

endpackage

>>> src/asgr_ifs.sv
// Interfaces: character request channel, text result channel and configuration write channel.
interface asgr_char_if;
    import asgr_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              restart;
    modport source (output valid, output char_code, output restart, input ready);
    modport sink   (input valid, input char_code, input restart, output ready);
endinterface

interface asgr_text_if;
    import asgr_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic [COLOR_W-1:0] out_color;
    modport source (output valid, output out_char, output out_color, input ready);
    modport sink   (input valid, input out_char, input out_color, output ready);
endinterface

interface asgr_cfg_if;
    import asgr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/ansi_sgr_color_parser.sv
// Top level: ANSI SGR escape sequence parser passing text characters with their colour.
//
//  channel      dir  payload                         handshake
//  char_stream  in   char_code[7:0], restart         valid/ready
//  text_stream  out  out_char[7:0], out_color[23:0]  valid/ready
//  cfg          in   data[23:0] (default colour)     valid/ready, ready always high
//
// One request per cycle; the parser state updates in the cycle of acceptance.
// A text result is registered in the output register, or in the skid entry on a stall.
// Output register plus one skid entry: requests keep flowing while one result waits.
// Reset clears to text state, bold off, colours 0xCCCCCC.
// char_stream.ready drops only while the skid entry is full.
module ansi_sgr_color_parser
    import asgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    asgr_char_if.sink  char_stream,
    asgr_text_if.source text_stream,
    asgr_cfg_if.sink   cfg
);

    typedef struct packed {
        logic               bold;
        logic [COLOR_W-1:0] color;
    } pend_t;

    scan_state_t        scan_state_reg, scan_state_next;
    logic               bold_on_reg, bold_on_next;
    logic [COLOR_W-1:0] current_color_reg, current_color_next;
    logic               pending_bold_reg, pending_bold_next;
    logic [COLOR_W-1:0] pending_color_reg, pending_color_next;
    logic [CODE_W-1:0]  code_value_reg, code_value_next;
    logic               code_has_digit_reg, code_has_digit_next;
    logic               code_bad_reg, code_bad_next;
    logic               seq_nonempty_reg, seq_nonempty_next;
    logic [COLOR_W-1:0] default_color_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               skid_valid_reg;
    logic [CHAR_W-1:0]  skid_char_reg;
    logic [COLOR_W-1:0] skid_color_reg;

    logic               in_fire;
    logic               out_fire;
    logic               emit;
    logic [CHAR_W-1:0]  c;
    pend_t              ev;
    logic [10:0]        acc;

    function automatic pend_t eval_code(
        input logic               pb,
        input logic [COLOR_W-1:0] pc,
        input logic [CODE_W-1:0]  v,
        input logic               has_digit,
        input logic               bad,
        input logic [COLOR_W-1:0] dflt
    );
        pend_t r;
        logic [CODE_W-1:0] off_fg;
        logic [CODE_W-1:0] off_br;
        r.bold  = pb;
        r.color = pc;
        off_fg  = v - CODE_FG_FIRST;
        off_br  = v - CODE_BR_FIRST;
        if (has_digit && !bad)
        begin
            if (v == CODE_RESET)
            begin
                r.bold  = 1'b0;
                r.color = dflt;
            end
            else if (v == CODE_BOLD)
            begin
                r.bold = 1'b1;
            end
            else if (v >= CODE_FG_FIRST && v <= CODE_FG_LAST)
            begin
                r.color = pb ? pal_bright(off_fg[2:0]) : pal_normal(off_fg[2:0]);
            end
            else if (v >= CODE_BR_FIRST && v <= CODE_BR_LAST)
            begin
                r.color = pal_bright(off_br[2:0]);
            end
            else if (v == CODE_FG_DFLT)
            begin
                r.color = dflt;
            end
        end
        return r;
    endfunction

    assign in_fire          = char_stream.valid && char_stream.ready;
    assign out_fire         = out_valid_reg && text_stream.ready;
    assign char_stream.ready = !skid_valid_reg;
    assign cfg.ready        = 1'b1;
    assign c                = char_stream.char_code;

    assign ev  = eval_code(pending_bold_reg, pending_color_reg, code_value_reg,
                           code_has_digit_reg, code_bad_reg, default_color_reg);
    assign acc = ({4'd0, code_value_reg} * 11'd10) + {7'd0, c[3:0]};

    always_comb
    begin
        scan_state_next     = scan_state_reg;
        bold_on_next        = bold_on_reg;
        current_color_next  = current_color_reg;
        pending_bold_next   = pending_bold_reg;
        pending_color_next  = pending_color_reg;
        code_value_next     = code_value_reg;
        code_has_digit_next = code_has_digit_reg;
        code_bad_next       = code_bad_reg;
        seq_nonempty_next   = seq_nonempty_reg;
        emit                = 1'b0;
        if (in_fire)
        begin
            if (char_stream.restart)
            begin
                scan_state_next     = ST_TEXT;
                bold_on_next        = 1'b0;
                current_color_next  = default_color_reg;
                pending_bold_next   = 1'b0;
                pending_color_next  = default_color_reg;
                code_value_next     = '0;
                code_has_digit_next = 1'b0;
                code_bad_next       = 1'b0;
                seq_nonempty_next   = 1'b0;
            end
            else
            begin
                case (scan_state_reg)
                    ST_ESC:
                    begin
                        if (c == CH_LBRACKET)
                        begin
                            scan_state_next     = ST_CSI;
                            pending_bold_next   = bold_on_reg;
                            pending_color_next  = current_color_reg;
                            code_value_next     = '0;
                            code_has_digit_next = 1'b0;
                            code_bad_next       = 1'b0;
                            seq_nonempty_next   = 1'b0;
                        end
                        else
                        begin
                            scan_state_next = ST_TEXT;
                        end
                    end
                    ST_CSI:
                    begin
                        if (is_letter(c))
                        begin
                            if (c == CH_FINAL_M)
                            begin
                                if (!seq_nonempty_reg)
                                begin
                                    bold_on_next       = 1'b0;
                                    current_color_next = default_color_reg;
                                end
                                else
                                begin
                                    pending_bold_next  = ev.bold;
                                    pending_color_next = ev.color;
                                    bold_on_next       = ev.bold;
                                    current_color_next = ev.color;
                                end
                            end
                            code_value_next     = '0;
                            code_has_digit_next = 1'b0;
                            code_bad_next       = 1'b0;
                            seq_nonempty_next   = 1'b0;
                            scan_state_next     = ST_TEXT;
                        end
                        else
                        begin
                            seq_nonempty_next = 1'b1;
                            if (c == CH_SEMICOLON)
                            begin
                                pending_bold_next   = ev.bold;
                                pending_color_next  = ev.color;
                                code_value_next     = '0;
                                code_has_digit_next = 1'b0;
                                code_bad_next       = 1'b0;
                            end
                            else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                            begin
                                code_value_next     = (acc > {4'd0, CODE_MAX}) ? CODE_MAX
                                                                              : acc[CODE_W-1:0];
                                code_has_digit_next = 1'b1;
                            end
                            else
                            begin
                                code_bad_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (c == CH_ESC)
                        begin
                            scan_state_next = ST_ESC;
                        end
                        else
                        begin
                            scan_state_next = ST_TEXT;
                            emit            = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state_reg     <= ST_TEXT;
            bold_on_reg        <= 1'b0;
            current_color_reg  <= DEFAULT_COLOR_RESET;
            pending_bold_reg   <= 1'b0;
            pending_color_reg  <= DEFAULT_COLOR_RESET;
            code_value_reg     <= '0;
            code_has_digit_reg <= 1'b0;
            code_bad_reg       <= 1'b0;
            seq_nonempty_reg   <= 1'b0;
            default_color_reg  <= DEFAULT_COLOR_RESET;
        end
        else
        begin
            scan_state_reg     <= scan_state_next;
            bold_on_reg        <= bold_on_next;
            current_color_reg  <= current_color_next;
            pending_bold_reg   <= pending_bold_next;
            pending_color_reg  <= pending_color_next;
            code_value_reg     <= code_value_next;
            code_has_digit_reg <= code_has_digit_next;
            code_bad_reg       <= code_bad_next;
            seq_nonempty_reg   <= seq_nonempty_next;
            if (cfg.valid && cfg.ready)
            begin
                default_color_reg <= cfg.data;
            end
        end
    end

    // Hold a stalled result; park a new one in the skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_char_reg  <= skid_char_reg;
                out_color_reg <= skid_color_reg;
            end
            else
            begin
                out_char_reg  <= c;
                out_color_reg <= current_color_reg;
            end
        end
        else if (emit)
        begin
            skid_char_reg  <= c;
            skid_color_reg <= current_color_reg;
        end
    end

    assign text_stream.valid     = out_valid_reg;
    assign text_stream.out_char  = out_char_reg;
    assign text_stream.out_color = out_color_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && char_stream.restart) |=> (scan_state_reg == ST_TEXT && !bold_on_reg))
        else $error("restart did not return to text state");

    a_text_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !char_stream.restart && scan_state_reg == ST_TEXT
         && char_stream.char_code != CH_ESC) |=> out_valid_reg)
        else $error("text character produced no result");

    a_esc_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !char_stream.restart && scan_state_reg == ST_TEXT
         && char_stream.char_code == CH_ESC) |=> (scan_state_reg == ST_ESC))
        else $error("escape not taken in text state");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !text_stream.ready && emit) |=> skid_valid_reg)
        else $error("result dropped under stall");

endmodule

>>> test/ansi_sgr_color_parser_tb.sv
// Testbench for the SGR colour parser: drives characters and escape sequences and checks the colour of every text character.
`timescale 1ns / 1ps

module ansi_sgr_color_parser_tb;
    import asgr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 115;

    localparam logic [COLOR_W-1:0] NORMAL_RGB [8] = '{
        24'h282C34, 24'hE06C75, 24'h98C379, 24'hE5C07B,
        24'h61AFEF, 24'hC678DD, 24'h56B6C2, 24'hABB2BF
    };
    localparam logic [COLOR_W-1:0] BRIGHT_RGB [8] = '{
        24'h5C6370, 24'hEF596F, 24'hA6E22E, 24'hE6DB74,
        24'h66D9EF, 24'hAE81FF, 24'hA1EFE4, 24'hF8F8F2
    };

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
    } text_item_t;

    logic clk;
    logic rst_n;

    asgr_char_if char_bus ();
    asgr_text_if text_bus ();
    asgr_cfg_if  cfg_bus ();

    ansi_sgr_color_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_bus),
        .text_stream (text_bus),
        .cfg         (cfg_bus)
    );

    text_item_t expected_text[$];
    int         error_count;
    int         items_sent;
    int         stuck_cycles;
    int         hold_left;
    bit         sender_gaps;
    bit         receiver_stalls;

    scan_state_t        scan_st;
    logic               bold_on;
    logic               pend_bold;
    logic [COLOR_W-1:0] cur_color;
    logic [COLOR_W-1:0] pend_color;
    logic [COLOR_W-1:0] dflt_color;
    logic [CODE_W-1:0]  code_val;
    logic               code_digit;
    logic               code_bad;
    logic               seq_busy;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_final_byte(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
            || c == 8'hAA || c == 8'hB5 || c == 8'hBA
            || (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
    endfunction

    task automatic clear_code_acc();
        code_val   = '0;
        code_digit = 1'b0;
        code_bad   = 1'b0;
    endtask

    task automatic apply_code();
        logic [2:0] idx;
        if (code_digit && !code_bad)
        begin
            if (code_val == CODE_RESET)
            begin
                pend_bold  = 1'b0;
                pend_color = dflt_color;
            end
            else if (code_val == CODE_BOLD)
                pend_bold = 1'b1;
            else if (code_val >= CODE_FG_FIRST && code_val <= CODE_FG_LAST)
            begin
                idx = 3'(code_val - CODE_FG_FIRST);
                pend_color = pend_bold ? BRIGHT_RGB[idx] : NORMAL_RGB[idx];
            end
            else if (code_val >= CODE_BR_FIRST && code_val <= CODE_BR_LAST)
            begin
                idx = 3'(code_val - CODE_BR_FIRST);
                pend_color = BRIGHT_RGB[idx];
            end
            else if (code_val == CODE_FG_DFLT)
                pend_color = dflt_color;
        end
        clear_code_acc();
    endtask

    task automatic back_to_text();
        scan_st    = ST_TEXT;
        bold_on    = 1'b0;
        cur_color  = dflt_color;
        pend_bold  = 1'b0;
        pend_color = dflt_color;
        seq_busy   = 1'b0;
        clear_code_acc();
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic rs);
        int acc;
        if (rs)
            back_to_text();
        else
        begin
            case (scan_st)
                ST_ESC:
                begin
                    if (c == CH_LBRACKET)
                    begin
                        scan_st    = ST_CSI;
                        pend_bold  = bold_on;
                        pend_color = cur_color;
                        seq_busy   = 1'b0;
                        clear_code_acc();
                    end
                    else
                        scan_st = ST_TEXT;
                end
                ST_CSI:
                begin
                    if (is_final_byte(c))
                    begin
                        if (c == CH_FINAL_M)
                        begin
                            if (!seq_busy)
                            begin
                                bold_on   = 1'b0;
                                cur_color = dflt_color;
                            end
                            else
                            begin
                                apply_code();
                                bold_on   = pend_bold;
                                cur_color = pend_color;
                            end
                        end
                        clear_code_acc();
                        seq_busy = 1'b0;
                        scan_st  = ST_TEXT;
                    end
                    else
                    begin
                        seq_busy = 1'b1;
                        if (c == CH_SEMICOLON)
                            apply_code();
                        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                        begin
                            acc        = int'(code_val) * 10 + int'(c - CH_DIGIT_0);
                            code_val   = (acc > int'(CODE_MAX)) ? CODE_MAX : CODE_W'(acc);
                            code_digit = 1'b1;
                        end
                        else
                            code_bad = 1'b1;
                    end
                end
                default:
                begin
                    if (c == CH_ESC)
                        scan_st = ST_ESC;
                    else
                        expected_text.push_back('{ch: c, color: cur_color});
                end
            endcase
        end
    endtask

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_text
        text_item_t want;
        if (rst_n && text_bus.valid && text_bus.ready)
        begin
            if (expected_text.size() == 0)
                report_error($sformatf("unexpected char %02h colour %06h",
                                       text_bus.out_char, text_bus.out_color));
            else
            begin
                want = expected_text.pop_front();
                if (text_bus.out_char !== want.ch)
                    report_error($sformatf("out_char %02h, want %02h",
                                           text_bus.out_char, want.ch));
                if (text_bus.out_color !== want.color)
                    report_error($sformatf("out_color %06h, want %06h for char %02h",
                                           text_bus.out_color, want.color, want.ch));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            text_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (receiver_stalls && $urandom_range(0, 99) < 6)
            text_bus.ready <= 1'b0;
        else
            text_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((char_bus.valid && char_bus.ready) || (text_bus.valid && text_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic rs);
        @(negedge clk);
        while (sender_gaps && $urandom_range(0, 99) < 6)
        begin
            char_bus.valid <= 1'b0;
            @(negedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        char_bus.restart   <= rs;
        do
            @(posedge clk);
        while (!char_bus.ready);
        parse_char(c, rs);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_default_color(input logic [COLOR_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        dflt_color = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_code_part();
        string part;
        string junk;
        int    pick;
        logic [CHAR_W-1:0] b;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0:       junk = "+";
            1:       junk = "-";
            2:       junk = " ";
            3:       junk = "\t";
            4:       junk = ":";
            default: junk = "\033";
        endcase
        if (pick < 10)
            part = "0";
        else if (pick < 20)
            part = "1";
        else if (pick < 45)
            part = $sformatf("%0d", 30 + $urandom_range(0, 7));
        else if (pick < 65)
            part = $sformatf("%0d", 90 + $urandom_range(0, 7));
        else if (pick < 72)
            part = "39";
        else if (pick < 80)
            part = $sformatf("%0d", $urandom_range(0, 999));
        else if (pick < 85)
            part = $sformatf("%03d", $urandom_range(0, 99));
        else if (pick < 89)
            part = "";
        else if (pick < 95)
            part = $urandom_range(0, 1) ? {junk, $sformatf("%0d", $urandom_range(0, 99))}
                                        : {$sformatf("%0d", $urandom_range(0, 99)), junk};
        else
        begin
            do
                b = CHAR_W'($urandom_range(0, 255));
            while (is_final_byte(b));
            part = $sformatf("%0d", $urandom_range(30, 37));
            send_string(part);
            send_char(b, 1'b0);
            part = "";
        end
        send_string(part);
    endtask

    task automatic send_sgr_run();
        int codes;
        logic [CHAR_W-1:0] fin;
        codes = $urandom_range(0, 4);
        send_char(CH_ESC, 1'b0);
        send_char(CH_LBRACKET, 1'b0);
        for (int i = 0; i < codes; i++)
        begin
            if (i > 0)
                send_char(CH_SEMICOLON, 1'b0);
            if ($urandom_range(0, 99) < 3)
            begin
                send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
                return;
            end
            send_code_part();
        end
        if ($urandom_range(0, 99) < 85)
            fin = CH_FINAL_M;
        else
        begin
            do
                fin = CHAR_W'($urandom_range(0, 255));
            while (!is_final_byte(fin));
        end
        send_char(fin, 1'b0);
    endtask

    task automatic test_plain_text();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h80, 1'b0);
        send_string("Az");
    endtask

    task automatic test_sgr_codes();
        send_string("\033[1;31mA");
        send_string("\033[mB");
        send_string("\033[+32; 33;999;94mC");
        send_string("\033[;35HD");
        send_string("\033\033E\033xF");
        send_string("\033[3\0332mG");
        send_string("\033[36");
        send_char(8'hAA, 1'b0);
        send_string("\033[1");
        send_char(8'hFF, 1'b1);
        send_string("H\033[0;1;39;7mI");
    endtask

    task automatic test_default_colour();
        write_default_color(24'h000000);
        send_string("\033[39mA");
        send_char(8'h00, 1'b1);
        send_char("B", 1'b0);
        write_default_color(24'hFFFFFF);
        send_string("C\033[0mD\033[mE");
        write_default_color(24'h5AA53C);
        send_string("F\033[31;39mG");
        send_char(8'h1B, 1'b1);
        send_char("H", 1'b0);
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_left = HOLD_CYCLES;
        repeat (60)
            send_char(CHAR_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [COLOR_W-1:0] palette_cfg [5];
        int start;
        int pick;
        palette_cfg = '{24'hFFFFFF, 24'h000000, 24'($urandom), 24'($urandom),
                        DEFAULT_COLOR_RESET};
        for (int phase = 0; phase < 5; phase++)
        begin
            write_default_color(palette_cfg[phase]);
            sender_gaps     = (phase != 2);
            receiver_stalls = (phase != 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_sgr_run();
                else if (pick < 88)
                    repeat ($urandom_range(1, 6))
                        send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
                else if (pick < 93)
                    send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
                else
                begin
                    send_char(CH_ESC, 1'b0);
                    send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.restart   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        text_bus.ready     = 1'b0;
        error_count        = 0;
        items_sent         = 0;
        stuck_cycles       = 0;
        hold_left          = 0;
        sender_gaps        = 1'b1;
        receiver_stalls    = 1'b1;
        dflt_color         = DEFAULT_COLOR_RESET;
        back_to_text();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_text();
        test_sgr_codes();
        test_default_colour();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_text.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_text.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/asgr_pkg.sv
src/asgr_ifs.sv
src/ansi_sgr_color_parser.sv
test/ansi_sgr_color_parser_tb.sv
